/* hdl/tccs_pkg.sv */
package tccs_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Fixed field widths
    localparam int CHAR_W  = 8;
    localparam int RROW_W  = 5;
    localparam int RCOL_W  = 7;
    localparam int CELL_W  = 16;
    localparam int ATTR_W  = 8;
    localparam int TAB_W   = 4;
    localparam int CFG_W   = 8;

    // Register reset values
    localparam logic [ATTR_W-1:0] ATTR_RST = 8'd7;
    localparam logic [TAB_W-1:0]  TAB_RST  = 4'd4;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Configuration register indexes
    typedef enum logic {
        CFG_ATTR = 1'b0,
        CFG_TAB  = 1'b1
    } t_cfg_idx;

    // Controller to datapath commands
    typedef struct packed {
        logic latch_in;   // capture input transaction
        logic clr_step;   // reset clearing pass: zero one cell
        logic scroll;     // advance ring top, row to last
        logic row_step;   // blank one cell of the bottom row
        logic wr_ctrl;    // apply newline / return / tab
        logic wrap;       // column to zero, next row
        logic store;      // write character cell, advance column
        logic rd;         // issue cell read
        logic out_load;   // load result register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic row_last;
        logic is_read;
        logic row_full;
        logic is_ctrl;
        logic col_full;
        logic out_free;
    } t_stat;

endpackage

/* hdl/tccs_in_if.sv */
interface tccs_in_if;
    import tccs_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [CHAR_W-1:0] char_code;
    logic              end_of_write;
    logic [RROW_W-1:0] read_row;
    logic [RCOL_W-1:0] read_col;

    modport source (
        output valid, op, char_code, end_of_write, read_row, read_col,
        input  ready
    );

    modport sink (
        input  valid, op, char_code, end_of_write, read_row, read_col,
        output ready
    );

endinterface

/* hdl/tccs_out_if.sv */
interface tccs_out_if;
    import tccs_pkg::*;

    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] cell_value;
    logic [RROW_W-1:0] cursor_row;
    logic [RCOL_W-1:0] cursor_col;
    logic              write_done;

    modport source (
        output valid, cell_value, cursor_row, cursor_col, write_done,
        input  ready
    );

    modport sink (
        input  valid, cell_value, cursor_row, cursor_col, write_done,
        output ready
    );

endinterface

/* hdl/tccs_ram.sv */
module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/tccs_ctrl.sv */
module tccs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tccs_pkg::t_stat i_stat,
    output tccs_pkg::t_cmd  o_cmd
);
    import tccs_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_SWEEP = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    t_cmd   cmd;
    logic   in_ready;

    // Next state and command decode
    always_comb begin
        n_state  = r_state;
        cmd      = '0;
        in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.latch_in = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.is_read) begin
                    cmd.rd  = 1'b1;
                    n_state = S_DONE;
                end else if (i_stat.row_full) begin
                    cmd.scroll = 1'b1;
                    n_state    = S_SWEEP;
                end else if (i_stat.is_ctrl) begin
                    cmd.wr_ctrl = 1'b1;
                    n_state     = S_DONE;
                end else if (i_stat.col_full) begin
                    cmd.wrap = 1'b1;
                end else begin
                    cmd.store = 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_SWEEP: begin
                cmd.row_step = 1'b1;
                if (i_stat.row_last) begin
                    n_state = S_EXEC;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    in_ready     = 1'b1;
                    if (i_in_valid) begin
                        cmd.latch_in = 1'b1;
                        n_state      = S_EXEC;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_ready = in_ready;

endmodule

/* hdl/tccs_dp.sv */
module tccs_dp #(
    parameter int COLUMNS = tccs_pkg::DEF_COLUMNS,
    parameter int ROWS    = tccs_pkg::DEF_ROWS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [tccs_pkg::CFG_W-1:0]  i_cfg_data,
    // input payload
    input  logic                        i_op,
    input  logic [tccs_pkg::CHAR_W-1:0] i_char_code,
    input  logic                        i_end_of_write,
    input  logic [tccs_pkg::RROW_W-1:0] i_read_row,
    input  logic [tccs_pkg::RCOL_W-1:0] i_read_col,
    // result register
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [tccs_pkg::CELL_W-1:0] o_cell_value,
    output logic [tccs_pkg::RROW_W-1:0] o_cursor_row,
    output logic [tccs_pkg::RCOL_W-1:0] o_cursor_col,
    output logic                        o_write_done,
    // control
    input  tccs_pkg::t_cmd              i_cmd,
    output tccs_pkg::t_stat             o_stat
);
    import tccs_pkg::*;

    localparam int CW     = $clog2(COLUMNS + 1);  // cursor column, holds COLUMNS
    localparam int CIW    = $clog2(COLUMNS);      // column index
    localparam int RW     = $clog2(ROWS + 1);     // cursor row, holds ROWS
    localparam int RIW    = $clog2(ROWS);         // row index
    localparam int ADDR_W = RIW + CIW;
    localparam int DEPTH  = ROWS << CIW;

    // Configuration registers
    logic [ATTR_W-1:0] r_attr;
    logic [TAB_W-1:0]  r_tab;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RST;
            r_tab  <= TAB_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ATTR: r_attr <= i_cfg_data[ATTR_W-1:0];
                CFG_TAB:  r_tab  <= i_cfg_data[TAB_W-1:0];
                default:  ;
            endcase
        end
    end

    // Captured transaction
    logic              r_op;
    logic [CHAR_W-1:0] r_ch;
    logic              r_eow;
    logic [RROW_W-1:0] r_rrow;
    logic [RCOL_W-1:0] r_rcol;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op   <= i_op;
            r_ch   <= i_char_code;
            r_eow  <= i_end_of_write;
            r_rrow <= i_read_row;
            r_rcol <= i_read_col;
        end
    end

    // Cursor, ring top and sweep counter
    logic [RW-1:0]     r_row, n_row;
    logic [CW-1:0]     r_col, n_col;
    logic [RIW-1:0]    r_top, n_top;
    logic [ADDR_W-1:0] r_cnt, n_cnt;

    logic [CW:0]    tab_sum;
    logic [RIW-1:0] bottom_phys;
    logic [RIW:0]   cur_sum;
    logic [RIW-1:0] cur_phys;
    logic [RIW:0]   rd_sum;
    logic [RIW-1:0] rd_phys;
    logic           rd_ok;

    assign tab_sum     = {1'b0, r_col} + (CW + 1)'(r_tab);
    assign bottom_phys = (r_top == '0) ? RIW'(ROWS - 1) : r_top - 1'b1;

    // Logical row to physical row through the ring offset
    assign cur_sum  = {1'b0, r_row[RIW-1:0]} + {1'b0, r_top};
    assign cur_phys = (cur_sum >= (RIW + 1)'(ROWS)) ? RIW'(cur_sum - (RIW + 1)'(ROWS))
                                                    : cur_sum[RIW-1:0];
    assign rd_sum   = {1'b0, RIW'(r_rrow)} + {1'b0, r_top};
    assign rd_phys  = (rd_sum >= (RIW + 1)'(ROWS)) ? RIW'(rd_sum - (RIW + 1)'(ROWS))
                                                   : rd_sum[RIW-1:0];
    assign rd_ok    = (int'(r_rrow) < ROWS) && (int'(r_rcol) < COLUMNS);

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        n_top = r_top;
        n_cnt = r_cnt;
        if (i_cmd.clr_step || i_cmd.row_step) begin
            n_cnt = r_cnt + 1'b1;
        end
        if (i_cmd.scroll) begin
            n_top = (r_top == RIW'(ROWS - 1)) ? '0 : r_top + 1'b1;
            n_row = RW'(ROWS - 1);
            n_cnt = '0;
        end
        if (i_cmd.wrap) begin
            n_col = '0;
            n_row = r_row + 1'b1;
        end
        if (i_cmd.store) begin
            n_col = r_col + 1'b1;
        end
        if (i_cmd.wr_ctrl) begin
            case (r_ch)
                CH_NEWLINE: begin
                    n_row = r_row + 1'b1;
                    n_col = '0;
                end
                CH_RETURN: begin
                    n_col = '0;
                end
                CH_TAB: begin
                    n_col = (tab_sum > (CW + 1)'(COLUMNS)) ? CW'(COLUMNS) : tab_sum[CW-1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_top <= '0;
            r_cnt <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
            r_top <= n_top;
            r_cnt <= n_cnt;
        end
    end

    // Screen memory write and read ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    always_comb begin
        ram_we    = i_cmd.clr_step | i_cmd.row_step | i_cmd.store;
        ram_waddr = r_cnt;
        ram_wdata = '0;
        if (i_cmd.row_step) begin
            ram_waddr = {bottom_phys, r_cnt[CIW-1:0]};
        end else if (i_cmd.store) begin
            ram_waddr = {cur_phys, r_col[CIW-1:0]};
            ram_wdata = {r_attr, r_ch};
        end
    end

    assign ram_raddr = {rd_phys, CIW'(r_rcol)};

    tccs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Remember whether the read hit the screen
    logic r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_ok <= rd_ok;
        end
    end

    // Result register
    logic              r_out_valid;
    logic [CELL_W-1:0] r_cell;
    logic [RROW_W-1:0] r_orow;
    logic [RCOL_W-1:0] r_ocol;
    logic              r_done;
    logic              out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_cell <= (r_op == OP_READ && r_rd_ok) ? ram_rdata : '0;
            r_orow <= RROW_W'(r_row);
            r_ocol <= RCOL_W'(r_col);
            r_done <= (r_op == OP_WRITE) ? r_eow : 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_value = r_cell;
    assign o_cursor_row = r_orow;
    assign o_cursor_col = r_ocol;
    assign o_write_done = r_done;

    // Status to controller
    assign o_stat.clr_last = (r_cnt == ADDR_W'(DEPTH - 1));
    assign o_stat.row_last = (r_cnt[CIW-1:0] == CIW'(COLUMNS - 1));
    assign o_stat.is_read  = (r_op == OP_READ);
    assign o_stat.row_full = (r_row == RW'(ROWS));
    assign o_stat.is_ctrl  = (r_ch == CH_TAB) || (r_ch == CH_NEWLINE) || (r_ch == CH_RETURN);
    assign o_stat.col_full = (r_col == CW'(COLUMNS));
    assign o_stat.out_free = out_free;

endmodule

/* hdl/text_console_cursor_scroll_core.sv */
// Channel   Direction  Content
// i_in_ch   in         op, char_code, end_of_write, read_row, read_col
// o_out_ch  out        cell_value, cursor_row, cursor_col, write_done
// i_cfg_*   in         write port: 0 cell_attribute, 1 tab_width
//
// A read or a plain character passes the execute and done states; a character
// past the last column first wraps to the next row. A scroll advances the
// ring top: the screen is a row ring in one RAM, and the new bottom row is
// blanked one cell per cycle through its single write port. After reset a
// clearing pass zeroes the RAM's ROWS * 2**clog2(COLUMNS) cells (3200 by
// default); no transaction is taken meanwhile. The result register holds while
// o_out_ch.ready is low, and the next transaction waits for it to drain.
module text_console_cursor_scroll_core #(
    parameter int COLUMNS = tccs_pkg::DEF_COLUMNS,
    parameter int ROWS    = tccs_pkg::DEF_ROWS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [tccs_pkg::CFG_W-1:0] i_cfg_data,
    tccs_in_if.sink                    i_in_ch,
    tccs_out_if.source                 o_out_ch
);
    import tccs_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer
    tccs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .o_in_ready (i_in_ch.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Cursor, screen memory and result register
    tccs_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_op           (i_in_ch.op),
        .i_char_code    (i_in_ch.char_code),
        .i_end_of_write (i_in_ch.end_of_write),
        .i_read_row     (i_in_ch.read_row),
        .i_read_col     (i_in_ch.read_col),
        .i_out_ready    (o_out_ch.ready),
        .o_out_valid    (o_out_ch.valid),
        .o_cell_value   (o_out_ch.cell_value),
        .o_cursor_row   (o_out_ch.cursor_row),
        .o_cursor_col   (o_out_ch.cursor_col),
        .o_write_done   (o_out_ch.write_done),
        .i_cmd          (cmd),
        .o_stat         (stat)
    );

endmodule
